FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/irwu_pkg.sv
package irwu_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam int STEP_W  = 32;
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 16;
    localparam int PER_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int LEN_W   = 8;
    localparam int LEVEL_W = 24;

    // Shared restoring divider: dividend width and steps per pass.
    localparam int DIV_W   = 40;
    // Accumulator for amplitude times mix numerator (24 x 32 bits signed).
    localparam int ACC_W   = 57;

    typedef enum logic [1:0] {
        CFG_PERIOD    = 2'd0,
        CFG_AMPLITUDE = 2'd1,
        CFG_OFFSET    = 2'd2,
        CFG_LENGTH    = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MUL_CUR = 2'd0,
        MUL_OLD = 2'd1,
        MUL_LO  = 2'd2,
        MUL_HI  = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load_wr;
        logic     mod_start;
        logic     phase_latch;
        logic     fetch_upd;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     quo_start;
        logic     out_write;
    } t_cmd;

    typedef struct packed {
        logic per_zero;
        logic phase_one;
        logic div_busy;
    } t_status;

endpackage

FILE: rtl/core/irwu_divider.sv
module irwu_divider
    import irwu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [PER_W-1:0]   i_divisor,
    output logic               o_busy,
    output logic [DIV_W-1:0]   o_quotient,
    output logic [PER_W-1:0]   o_remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [PER_W-1:0] r_rem;
    logic [DIV_W-1:0] r_q;
    logic [PER_W-1:0] r_div;

    logic [PER_W:0]   shifted;
    logic             ge;

    // One quotient bit per cycle: the dividend shifts out of the top of r_q
    // while quotient bits shift in at the bottom.
    assign shifted = {r_rem, r_q[DIV_W-1]};
    assign ge      = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? PER_W'(shifted - {1'b0, r_div}) : shifted[PER_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/core/irwu_datapath.sv
module irwu_datapath
    import irwu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [GAIN_W-1:0]  i_cfg_data,
    input  logic [STEP_W-1:0]  i_step,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic [VAL_W-1:0]   i_val,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [LEVEL_W-1:0] o_level,
    output logic               o_new_sample
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int SW   = LEVEL_W + 2;
    localparam logic signed [SW-1:0] LEVEL_MAX = SW'(2 ** (LEVEL_W - 1) - 1);
    localparam logic signed [SW-1:0] LEVEL_MIN = -SW'(2 ** (LEVEL_W - 1));

    // Configuration registers.
    logic [PER_W-1:0]         r_period;
    logic signed [GAIN_W-1:0] r_amp;
    logic signed [GAIN_W-1:0] r_offset;
    logic [LEN_W-1:0]         r_len;

    // Sample table and waveform state.
    logic [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] r_rd;
    logic [VAL_W-1:0] r_old;
    logic [VAL_W-1:0] r_cur;
    logic [AW-1:0]    r_pos;

    // Per-item working registers.
    logic [PER_W-1:0]        r_phase;
    logic                    r_fetched;
    logic signed [ACC_W-1:0] r_acc;
    logic [15:0]             r_num_hi;
    logic                    r_neg;
    logic [LEVEL_W-1:0]      r_level;
    logic                    r_new_sample;

    logic                    idx_ok;
    logic [AW-1:0]           wr_addr;
    logic                    rd_en;
    logic [CW-1:0]           pos_inc;
    logic [CW-1:0]           len_eff;
    logic [AW-1:0]           pos_next;

    logic [PER_W-1:0]        phase_c;
    logic                    phase_one;

    logic signed [24:0]      mul_a;
    logic signed [16:0]      mul_b;
    logic signed [41:0]      mul_p;

    logic [DIV_W:0]          scaled;
    logic [DIV_W-1:0]        mag;
    logic                    div_start;
    logic [DIV_W-1:0]        div_dividend;
    logic                    div_busy;
    logic [DIV_W-1:0]        div_quo;
    logic [PER_W-1:0]        div_rem;

    logic [SW-1:0]           q_ext;
    logic signed [SW-1:0]    term;
    logic signed [SW-1:0]    sum;
    logic [LEVEL_W-1:0]      level_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PER_W'(1);
            r_amp    <= GAIN_W'(65536);
            r_offset <= '0;
            r_len    <= LEN_W'(100);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PERIOD:    r_period <= i_cfg_data[PER_W-1:0];
                CFG_AMPLITUDE: r_amp    <= i_cfg_data;
                CFG_OFFSET:    r_offset <= i_cfg_data;
                CFG_LENGTH:    r_len    <= i_cfg_data[LEN_W-1:0];
                default:       r_len    <= r_len;
            endcase
        end
    end

    // Table write from a load transfer, read when the phase wraps to one.
    assign idx_ok  = 32'(i_idx) < TABLE_DEPTH;
    assign wr_addr = AW'(32'(i_idx));
    assign rd_en   = i_cmd.phase_latch && phase_one;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && idx_ok) begin
            r_mem[wr_addr] <= i_val;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_pos];
        end
    end

    // Effective length is the register limited to the table depth; zero acts as one.
    assign pos_inc  = CW'(r_pos) + CW'(1);
    assign len_eff  = (CW'(r_len) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_len);
    assign pos_next = (pos_inc >= len_eff) ? '0 : r_pos + AW'(1);

    assign phase_c   = (div_rem == '0) ? r_period : div_rem;
    assign phase_one = phase_c == PER_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old <= '0;
            r_cur <= '0;
            r_pos <= '0;
        end else begin
            if (rd_en) begin
                r_pos <= pos_next;
            end
            if (i_cmd.fetch_upd) begin
                r_old <= r_cur;
                r_cur <= r_rd;
            end
        end
    end

    // One shared multiplier: first the mix numerator, then amplitude times
    // the numerator in two 16-bit halves.
    always_comb begin
        mul_a = $signed({9'b0, r_cur});
        mul_b = $signed({1'b0, r_phase});
        case (i_cmd.mul_sel)
            MUL_CUR: begin
                mul_a = $signed({9'b0, r_cur});
                mul_b = $signed({1'b0, r_phase});
            end
            MUL_OLD: begin
                mul_a = $signed({9'b0, r_old});
                mul_b = $signed({1'b0, r_period - r_phase});
            end
            MUL_LO: begin
                mul_a = 25'(r_amp);
                mul_b = $signed({1'b0, r_acc[15:0]});
            end
            MUL_HI: begin
                mul_a = 25'(r_amp);
                mul_b = $signed({1'b0, r_num_hi});
            end
            default: begin
                mul_a = $signed({9'b0, r_cur});
                mul_b = $signed({1'b0, r_phase});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase_latch) begin
            r_phase   <= phase_c;
            r_fetched <= phase_one;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_CUR: r_acc <= ACC_W'(mul_p);
                MUL_OLD: r_acc <= r_acc + ACC_W'(mul_p);
                MUL_LO: begin
                    r_acc    <= ACC_W'(mul_p);
                    r_num_hi <= r_acc[31:16];
                end
                MUL_HI:  r_acc <= r_acc + (ACC_W'(mul_p) <<< 16);
                default: r_acc <= r_acc;
            endcase
        end
        if (i_cmd.quo_start) begin
            r_neg <= scaled[DIV_W];
        end
    end

    // floor(x / (P * 2^16)) = floor(floor(x / 2^16) / P). A negative value y
    // is divided as ~y, and the floored quotient is then ~q.
    assign scaled       = r_acc[ACC_W-1:16];
    assign mag          = scaled[DIV_W] ? ~scaled[DIV_W-1:0] : scaled[DIV_W-1:0];
    assign div_start    = i_cmd.mod_start || i_cmd.quo_start;
    assign div_dividend = i_cmd.mod_start ? DIV_W'(i_step) : mag;

    irwu_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_period),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign q_ext = SW'(div_quo[LEVEL_W-1:0]);
    assign term  = r_neg ? $signed(~q_ext) : $signed(q_ext);
    assign sum   = SW'(r_offset) + term;

    always_comb begin
        if (sum > LEVEL_MAX) begin
            level_sat = LEVEL_MAX[LEVEL_W-1:0];
        end else if (sum < LEVEL_MIN) begin
            level_sat = LEVEL_MIN[LEVEL_W-1:0];
        end else begin
            level_sat = sum[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_level      <= level_sat;
            r_new_sample <= r_fetched;
        end
    end

    assign o_status.per_zero  = r_period == '0;
    assign o_status.phase_one = phase_one;
    assign o_status.div_busy  = div_busy;

    assign o_level      = r_level;
    assign o_new_sample = r_new_sample;

endmodule

FILE: rtl/core/irwu_ctrl.sv
module irwu_ctrl
    import irwu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_action,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_PHASE,
        S_FETCH,
        S_MUL_CUR,
        S_MUL_OLD,
        S_MUL_LO,
        S_MUL_HI,
        S_QUO,
        S_DIVW,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_action) begin
                        o_cmd.load_wr = 1'b1;
                    end else if (!i_status.per_zero) begin
                        o_cmd.mod_start = 1'b1;
                        n_state         = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (!i_status.div_busy) begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE: begin
                o_cmd.phase_latch = 1'b1;
                n_state = i_status.phase_one ? S_FETCH : S_MUL_CUR;
            end
            S_FETCH: begin
                o_cmd.fetch_upd = 1'b1;
                n_state         = S_MUL_CUR;
            end
            S_MUL_CUR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CUR;
                n_state       = S_MUL_OLD;
            end
            S_MUL_OLD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_OLD;
                n_state       = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state       = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
                n_state       = S_QUO;
            end
            S_QUO: begin
                o_cmd.quo_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (!i_status.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // The result waits here only while the previous one is untaken.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_write ? 1'b1 : (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/interpolated_random_waveform_unit.sv
// A tick takes the step modulo the period, fetches a sample when the phase wraps to
// one, forms the mix and gain products and divides (two 40-step passes of the shared
// one-bit-per-cycle divider), and input stalls until its result is written.
// A finished result is held in an output register while the next item is accepted.
// Reset (synchronous, active low): registers to defaults, samples and position to
// zero; the sample table is not cleared and holds garbage until loaded.
`include "assert_macros.svh"

module interpolated_random_waveform_unit
    import irwu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [GAIN_W-1:0]  i_cfg_data,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] computation_step, [38:32] entry_index, [54:39] entry_value, [55] zero
    input  logic [55:0]        s_axis_tdata,
    // [0] action
    input  logic [0:0]         s_axis_tuser,

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [23:0] level
    output logic [LEVEL_W-1:0] m_axis_tdata,
    // [0] new_sample
    output logic [0:0]         m_axis_tuser
);

    t_cmd    cmd;
    t_status status;
    logic    new_sample;

    assign o_cfg_ready = 1'b1;

    irwu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    irwu_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_step       (s_axis_tdata[31:0]),
        .i_idx        (s_axis_tdata[38:32]),
        .i_val        (s_axis_tdata[54:39]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_level      (m_axis_tdata),
        .o_new_sample (new_sample)
    );

    assign m_axis_tuser[0] = new_sample;

    `ASSERT_CLK(a_tick_blocks_input, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !status.per_zero) |=> !s_axis_tready, "tick transfer did not start work")
    `ASSERT_CLK(a_load_keeps_ready, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> s_axis_tready, "load transfer stalled the input")
    `ASSERT_CLK(a_no_overwrite, i_clk, i_rst_n, cmd.out_write |-> (!m_axis_tvalid || m_axis_tready), "result written over an untaken result")
    `ASSERT_CLK(a_valid_from_write, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(cmd.out_write), "result valid without a result write")

endmodule

FILE: tb/tb.sv
module tb;
    import irwu_pkg::*;

    localparam int      TBL_DEPTH    = TABLE_DEPTH_DEF;
    localparam int      DRAIN_CYCLES = 120;
    localparam int      CYCLE_LIMIT  = 1000000;
    localparam logic    ACT_TICK     = 1'b0;
    localparam logic    ACT_LOAD     = 1'b1;
    localparam longint  LEVEL_TOP    = (longint'(1) <<< (LEVEL_W - 1)) - 1;
    localparam longint  LEVEL_BOTTOM = -LEVEL_TOP - 1;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               fetched;
    } t_level_rec;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    t_cfg_reg           i_cfg_index   = CFG_PERIOD;
    logic [GAIN_W-1:0]  i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [55:0]        s_axis_tdata  = '0;
    logic [0:0]         s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [LEVEL_W-1:0] m_axis_tdata;
    logic [0:0]         m_axis_tuser;

    // Shadow copy of the generator state, updated at each accepted transfer.
    logic [PER_W-1:0]   period_reg = 16'd1;
    logic [GAIN_W-1:0]  amp_reg    = 24'd65536;
    logic [GAIN_W-1:0]  offset_reg = '0;
    logic [LEN_W-1:0]   len_reg    = 8'd100;
    logic [VAL_W-1:0]   sample_mem [TBL_DEPTH];
    logic [VAL_W-1:0]   old_smp    = '0;
    logic [VAL_W-1:0]   cur_smp    = '0;
    int                 position   = 0;

    t_level_rec         pending_levels [$];
    t_level_rec         oldest;

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int cycle_count     = 0;
    int error_count     = 0;
    int tick_count      = 0;
    int load_count      = 0;
    int cfg_writes      = 0;
    int results_checked = 0;

    interpolated_random_waveform_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (pending_levels.size() == 0) begin
                report_mismatch("result transfer with no tick pending");
            end else begin
                oldest = pending_levels.pop_front();
                if (m_axis_tdata !== oldest.level) begin
                    report_mismatch($sformatf("level got %h, expected %h",
                                              m_axis_tdata, oldest.level));
                end
                if (m_axis_tuser[0] !== oldest.fetched) begin
                    report_mismatch($sformatf("new_sample got %b, expected %b",
                                              m_axis_tuser[0], oldest.fetched));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout with %0d results outstanding", pending_levels.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Works out the result of one tick and queues it; a zero period yields nothing.
    function automatic void advance_waveform(input logic [STEP_W-1:0] step);
        logic [31:0] phase;
        logic [31:0] rest;
        longint      mix;
        longint      prod;
        longint      den;
        longint      term;
        longint      total;
        int          eff_len;
        int          nxt;
        t_level_rec  rec;
        if (period_reg == 0) return;
        phase = step % period_reg;
        if (phase == 0) phase = period_reg;
        rec.fetched = 1'b0;
        if (phase == 1) begin
            old_smp = cur_smp;
            cur_smp = sample_mem[position];
            eff_len = (len_reg > TBL_DEPTH) ? TBL_DEPTH : int'(len_reg);
            nxt = position + 1;
            if (nxt >= eff_len) nxt = 0;
            position = nxt;
            rec.fetched = 1'b1;
        end
        rest = period_reg - phase;
        mix = longint'(cur_smp) * longint'(phase) + longint'(old_smp) * longint'(rest);
        prod = longint'($signed(amp_reg)) * mix;
        den = longint'(period_reg) * 65536;
        // Round toward minus infinity, unlike the truncating divide operator.
        if (prod >= 0) term = prod / den;
        else term = -((-prod + den - 1) / den);
        total = longint'($signed(offset_reg)) + term;
        if (total > LEVEL_TOP) total = LEVEL_TOP;
        if (total < LEVEL_BOTTOM) total = LEVEL_BOTTOM;
        rec.level = total[LEVEL_W-1:0];
        pending_levels.push_back(rec);
    endfunction

    task automatic send_item(input logic act, input logic [STEP_W-1:0] step,
                             input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, idx, step};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        if (act == ACT_LOAD) begin
            sample_mem[idx] = val;
            load_count++;
        end else begin
            advance_waveform(step);
            tick_count++;
        end
    endtask

    task automatic tick(input logic [STEP_W-1:0] step);
        send_item(ACT_TICK, step, IDX_W'($urandom), VAL_W'($urandom));
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_reg which, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (which)
            CFG_PERIOD:    period_reg = data[PER_W-1:0];
            CFG_AMPLITUDE: amp_reg    = data;
            CFG_OFFSET:    offset_reg = data;
            CFG_LENGTH:    len_reg    = data[LEN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic configure(input logic [PER_W-1:0] per, input logic [GAIN_W-1:0] amp,
                             input logic [GAIN_W-1:0] off, input logic [LEN_W-1:0] len);
        write_reg(CFG_PERIOD, GAIN_W'(per));
        write_reg(CFG_AMPLITUDE, amp);
        write_reg(CFG_OFFSET, off);
        write_reg(CFG_LENGTH, GAIN_W'(len));
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every result has arrived, then lets a tick that gives no
    // result finish inside the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_table();
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (i == 0) send_item(ACT_LOAD, $urandom, IDX_W'(i), 16'hFFFF);
            else if (i == 1) send_item(ACT_LOAD, $urandom, IDX_W'(i), 16'h0000);
            else send_item(ACT_LOAD, $urandom, IDX_W'(i), VAL_W'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        tick(32'd0);
        tick(32'hFFFF_FFFF);
        tick(32'd7);
    endtask

    task automatic test_interpolation();
        settle();
        configure(16'd4, 24'd65536, 24'd0, 8'd100);
        for (int s = 5; s <= 9; s++) tick(STEP_W'(s));
    endtask

    task automatic test_saturation();
        settle();
        configure(16'd2, 24'h7FFFFF, 24'h7FFFFF, 8'd100);
        tick(32'd3);
        tick(32'd4);
        settle();
        configure(16'd2, 24'h800000, 24'h800000, 8'd100);
        tick(32'd5);
        tick(32'd6);
    endtask

    task automatic test_zero_period();
        settle();
        configure(16'd0, 24'd65536, 24'hFF8000, 8'd100);
        tick(32'd1);
        tick(32'd2);
        settle();
        configure(16'd3, 24'd65536, 24'hFF8000, 8'd100);
        tick(32'd1);
        tick(32'd2);
    endtask

    task automatic test_table_length();
        settle();
        configure(16'd1, 24'd131072, 24'd0, 8'd0);
        tick(32'd10);
        tick(32'd11);
        settle();
        configure(16'd1, 24'd131072, 24'd0, 8'd255);
        tick(32'd12);
        settle();
        configure(16'd1, 24'd65536, 24'd0, 8'd100);
        for (int s = 0; s < 4; s++) tick(STEP_W'(s));
        // The length drops below the position: one more fetch there, then wrap.
        settle();
        configure(16'd1, 24'd65536, 24'd0, 8'd2);
        tick(32'd20);
        tick(32'd21);
    endtask

    task automatic run_traffic(input int idle, input int stall);
        int               n;
        int               sent;
        int               run;
        int               r;
        logic [PER_W-1:0] per;
        logic [GAIN_W-1:0] amp;
        logic [GAIN_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [STEP_W-1:0] base;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int grp = 0; grp < 5; grp++) begin
            r = $urandom_range(99);
            if (r < 55) per = PER_W'($urandom_range(1, 6));
            else if (r < 75) per = PER_W'($urandom_range(7, 40));
            else if (r < 90) per = PER_W'($urandom);
            else if (r < 95) per = 16'hFFFF;
            else per = '0;
            if ($urandom_range(1)) amp = GAIN_W'($urandom);
            else amp = GAIN_W'($urandom_range(0, 262143) - 131072);
            if ($urandom_range(1)) off = GAIN_W'($urandom);
            else off = GAIN_W'($urandom_range(0, 131071) - 65536);
            r = $urandom_range(99);
            if (r < 70) len = LEN_W'($urandom_range(1, 8));
            else if (r < 85) len = LEN_W'($urandom_range(9, TBL_DEPTH));
            else len = LEN_W'($urandom);
            settle();
            configure(per, amp, off, len);
            n = (per == 0) ? 6 : $urandom_range(20, 36);
            sent = 0;
            while (sent < n) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    send_item(ACT_LOAD, $urandom, IDX_W'($urandom), VAL_W'($urandom));
                    sent++;
                end else if (r < 20) begin
                    tick($urandom);
                    sent++;
                end else begin
                    // Consecutive steps, half the time started close to a period boundary.
                    run = (per < 8) ? $urandom_range(1, 2 * per + 3) : $urandom_range(1, 12);
                    if (run > n - sent) run = n - sent;
                    if ($urandom_range(1)) base = $urandom;
                    else base = STEP_W'(per) * $urandom_range(0, 65535) - $urandom_range(0, 2);
                    for (int i = 0; i < run; i++) tick(base + STEP_W'(i));
                    sent += run;
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fill_table();
        test_reset_defaults();
        test_interpolation();
        test_saturation();
        test_zero_period();
        test_table_length();
        run_traffic(0, 0);
        run_traffic(76, 0);
        run_traffic(0, 76);
        run_traffic(28, 28);
        settle();
        $display("Sent %0d ticks and %0d table loads over %0d register writes.",
                 tick_count, load_count, cfg_writes);
        $display("Compared %0d results with and without input gaps and output stalls.",
                 results_checked);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
